// ===== src/edge_list_positional_buffer_unit_macros.svh =====
// assertion macros for the edge list positional buffer
// no dependencies; taken in by the top level
`ifndef EDGE_LIST_POSITIONAL_BUFFER_UNIT_MACROS_SVH
`define EDGE_LIST_POSITIONAL_BUFFER_UNIT_MACROS_SVH

// same-cycle implication
`define ELPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ELPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/elpb_pkg.sv =====
// shared types and constants for the edge list positional buffer
// no dependencies
package elpb_pkg;

    localparam int CMD_W    = 3;
    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 6;
    localparam int SLOT_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } elpb_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_FULL    = 2'd3
    } elpb_status_t;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_ROTATE = 2'd3
    } elpb_mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } elpb_state_t;

    typedef struct packed {
        elpb_mode_t        mode;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] count;
    } elpb_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [NODE_W-1:0]   start_node;
        logic [NODE_W-1:0]   end_node;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [POS_W-1:0]    position;
    } elpb_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry_count;
        logic                entry_valid;
        logic [NODE_W-1:0]   out_start_node;
        logic [NODE_W-1:0]   out_end_node;
        logic [WEIGHT_W-1:0] out_edge_weight;
        logic                last_of_run;
    } elpb_out_t;

endpackage

// ===== src/elpb_cell.sv =====
// one storage cell of the edge chain
// depends on elpb_pkg
module elpb_cell #(
    parameter int INDEX  = 0,
    parameter int EDGE_W = 36
) (
    input  logic                clk,
    input  elpb_pkg::elpb_ctrl_t ctrl,
    input  logic [EDGE_W-1:0]   new_edge,
    input  logic [EDGE_W-1:0]   left_edge,
    input  logic [EDGE_W-1:0]   right_edge,
    input  logic [EDGE_W-1:0]   head_edge,
    output logic [EDGE_W-1:0]   cell_edge
);
    import elpb_pkg::*;

    localparam logic [SLOT_W-1:0] IDX  = SLOT_W'(INDEX);
    localparam logic [SLOT_W-1:0] IDX1 = SLOT_W'(INDEX + 1);

    logic [EDGE_W-1:0] edge_reg;
    logic [EDGE_W-1:0] edge_next;

    always_comb
    begin
        edge_next = edge_reg;
        case (ctrl.mode)
            MODE_INSERT:
            begin
                if (IDX > ctrl.slot)
                begin
                    edge_next = left_edge;
                end
                else if (IDX == ctrl.slot)
                begin
                    edge_next = new_edge;
                end
            end
            MODE_DELETE:
            begin
                if (IDX >= ctrl.slot)
                begin
                    edge_next = right_edge;
                end
            end
            MODE_ROTATE:
            begin
                if (IDX1 < ctrl.count)
                begin
                    edge_next = right_edge;
                end
                else if (IDX1 == ctrl.count)
                begin
                    edge_next = head_edge;
                end
            end
            default:
            begin
                edge_next = edge_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
    end

    assign cell_edge = edge_reg;

endmodule

// ===== src/elpb_chain.sv =====
// row of edge cells, each linked to the neighbours it has
// depends on elpb_pkg and elpb_cell
module elpb_chain #(
    parameter int CAPACITY = 32,
    parameter int EDGE_W   = 36
) (
    input  logic                 clk,
    input  elpb_pkg::elpb_ctrl_t ctrl,
    input  logic [EDGE_W-1:0]    new_edge,
    output logic [EDGE_W-1:0]    head_edge
);
    import elpb_pkg::*;

    logic [EDGE_W-1:0] cell_q [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [EDGE_W-1:0] left_edge;
        logic [EDGE_W-1:0] right_edge;

        if (g == 0)
        begin : g_first
            assign left_edge = cell_q[0];
        end
        else
        begin : g_left
            assign left_edge = cell_q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_edge = '0;
        end
        else
        begin : g_right
            assign right_edge = cell_q[g+1];
        end

        elpb_cell #(
            .INDEX  (g),
            .EDGE_W (EDGE_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_edge   (new_edge),
            .left_edge  (left_edge),
            .right_edge (right_edge),
            .head_edge  (cell_q[0]),
            .cell_edge  (cell_q[g])
        );
    end

    assign head_edge = cell_q[0];

endmodule

// ===== src/edge_list_positional_buffer_unit.sv =====
// top level of the edge list positional buffer: command decode, dump sequencer
// depends on elpb_pkg, elpb_chain and the assertion macro header
//
// usage
//   req channel: one command transaction (insert/delete at front, back or a
//   position, or dump); rsp channel: result transactions
//   edits: one rsp transaction each, registered in the cycle after acceptance;
//   a new command is taken every cycle while the rsp register drains
//   every cell of the chain shifts in parallel, so an edit moves all cells at once
//   dump of n edges: n rsp transactions, one per cycle while rsp_ready is high,
//   last_of_run on the final one; the chain rotates one place per entry and
//   is back in order after the last; req_ready is low for the whole dump
//   dump of an empty buffer and the unused command give one rsp transaction
//   errors (bad position, empty, full) leave the buffer unchanged
//   reset empties the buffer; entry contents are not cleared
//   when rsp_ready is low while rsp_valid is high the rsp register holds,
//   req_ready drops and a running dump pauses without losing its place
module edge_list_positional_buffer_unit #(
    parameter int CAPACITY    = 32,
    parameter int VERTEX_BITS = 10,
    parameter int WEIGHT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  elpb_pkg::elpb_in_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output elpb_pkg::elpb_out_t rsp
);
    import elpb_pkg::*;
    `include "edge_list_positional_buffer_unit_macros.svh"

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int EDGE_W = 2 * VERTEX_BITS + WEIGHT_BITS;

    elpb_state_t       state_reg;
    elpb_state_t       state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  dump_idx_reg;
    logic [CNT_W-1:0]  dump_idx_next;
    elpb_out_t         out_reg;
    elpb_out_t         out_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              out_free;
    logic              accept;
    logic              dump_last;
    logic              is_empty;
    logic              is_full;
    logic [SLOT_W-1:0] pos_s;
    logic [SLOT_W-1:0] cnt_s;
    elpb_ctrl_t        ctrl;
    logic [EDGE_W-1:0] new_edge;
    logic [EDGE_W-1:0] head_edge;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign pos_s     = SLOT_W'(req.position);
    assign cnt_s     = SLOT_W'(count_reg);
    assign dump_last = (CNT_W'(dump_idx_reg + 1'b1) == count_reg);
    assign new_edge  = {VERTEX_BITS'(req.start_node), VERTEX_BITS'(req.end_node),
                        WEIGHT_BITS'(req.edge_weight)};

    elpb_chain #(
        .CAPACITY (CAPACITY),
        .EDGE_W   (EDGE_W)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_edge  (new_edge),
        .head_edge (head_edge)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.cmd == CMD_DUMP) && !is_empty)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (out_free && dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // decode and datapath
    always_comb
    begin
        elpb_status_t st;
        logic         edit;
        st             = STAT_OK;
        edit           = 1'b0;
        ctrl.mode      = MODE_HOLD;
        ctrl.slot      = '0;
        ctrl.count     = cnt_s;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;

        case (state_reg)
            ST_IDLE:
            begin
                dump_idx_next = '0;
                if (accept)
                begin
                    case (req.cmd)
                        CMD_INS_FRONT:
                        begin
                            if (is_full)
                            begin
                                st = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.mode = MODE_INSERT;
                                ctrl.slot = '0;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                st = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.mode = MODE_INSERT;
                                ctrl.slot = cnt_s;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_INS_AT:
                        begin
                            if (pos_s > cnt_s)
                            begin
                                st = STAT_BAD_POS;
                            end
                            else if (is_full)
                            begin
                                st = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.mode = MODE_INSERT;
                                ctrl.slot = pos_s;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DEL_FRONT:
                        begin
                            if (is_empty)
                            begin
                                st = STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.mode = MODE_DELETE;
                                ctrl.slot = '0;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_DEL_BACK:
                        begin
                            if (is_empty)
                            begin
                                st = STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.mode = MODE_DELETE;
                                ctrl.slot = cnt_s - 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_DEL_AT:
                        begin
                            if (is_empty)
                            begin
                                st = STAT_EMPTY;
                            end
                            else if (pos_s >= cnt_s)
                            begin
                                st = STAT_BAD_POS;
                            end
                            else
                            begin
                                ctrl.mode = MODE_DELETE;
                                ctrl.slot = pos_s;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_DUMP:
                        begin
                            edit = is_empty;
                        end
                        default:
                        begin
                            st = STAT_OK;
                        end
                    endcase
                    if (req.cmd != CMD_DUMP)
                    begin
                        edit = 1'b1;
                    end
                    if (edit)
                    begin
                        out_valid_next           = 1'b1;
                        out_next.status          = st;
                        out_next.entry_count     = ENTRY_W'(count_next);
                        out_next.entry_valid     = 1'b0;
                        out_next.out_start_node  = '0;
                        out_next.out_end_node    = '0;
                        out_next.out_edge_weight = '0;
                        out_next.last_of_run     = 1'b1;
                    end
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    ctrl.mode                = MODE_ROTATE;
                    dump_idx_next            = dump_idx_reg + 1'b1;
                    out_valid_next           = 1'b1;
                    out_next.status          = STAT_OK;
                    out_next.entry_count     = ENTRY_W'(count_reg);
                    out_next.entry_valid     = 1'b1;
                    out_next.out_start_node  =
                        NODE_W'(head_edge[EDGE_W-1 -: VERTEX_BITS]);
                    out_next.out_end_node    =
                        NODE_W'(head_edge[WEIGHT_BITS +: VERTEX_BITS]);
                    out_next.out_edge_weight = WEIGHT_W'(head_edge[WEIGHT_BITS-1:0]);
                    out_next.last_of_run     = dump_last;
                end
            end
            default:
            begin
                ctrl.mode = MODE_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `ELPB_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `ELPB_ASSERT_NOW(a_no_req_in_dump, state_reg == ST_DUMP, !req_ready, "command taken during dump")
    `ELPB_ASSERT_NEXT(a_dump_end, (state_reg == ST_DUMP) && out_free && dump_last, (state_reg == ST_IDLE) && rsp_valid && rsp.last_of_run, "dump did not finish on last entry")
    `ELPB_ASSERT_NEXT(a_count_step, 1'b1, (count_reg == $past(count_reg)) || (count_reg == CNT_W'($past(count_reg) + 1'b1)) || (count_reg == CNT_W'($past(count_reg) - 1'b1)), "fill count moved by more than one")

endmodule
